### rtl/fcp_pkg.sv
// Shared constants for the free-fly camera pose block: command codes, row codes,
// CORDIC gain and arc-tangent table. No dependencies.
package fcp_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int POS_BITS_DEF   = 32;

  localparam int CORDIC_STEPS = 28;
  localparam int CW           = 34;

  localparam logic [2:0] CMD_LEFT  = 3'd0;
  localparam logic [2:0] CMD_FRONT = 3'd1;
  localparam logic [2:0] CMD_UP    = 3'd2;
  localparam logic [2:0] CMD_YAW   = 3'd3;
  localparam logic [2:0] CMD_PITCH = 3'd4;

  localparam logic [1:0] ROW_SIDE = 2'd0;
  localparam logic [1:0] ROW_UP   = 2'd1;
  localparam logic [1:0] ROW_BACK = 2'd2;

  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

  // arctan(2^-i) as a fraction of a full turn (turn = 2^32)
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### rtl/free_fly_camera_pose.sv
// Free-fly camera pose: position, yaw and pitch, with look-at view matrix rows.
// The shared CORDIC stage runs 28 iterations for yaw and again for pitch, each
// with a load and a rounding step. A move updates the three position coordinates
// in turn on the shared multiply-accumulate unit. A turn does a reciprocal
// multiply for the divide by 45, then the phase update. The direction vectors
// are then computed on the multiply-accumulate unit, and each of the three rows
// takes a translation dot product on it before it is held on the output until
// taken. stall_o stays high from acceptance until the last row's transaction
// completes. After reset the block computes the initial direction vectors with
// stall_o high.
// Depends on fcp_pkg.
module free_fly_camera_pose #(
  parameter int ANGLE_BITS = fcp_pkg::ANGLE_BITS_DEF,
  parameter int POS_BITS   = fcp_pkg::POS_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [15:0] amount_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [1:0]         row_o,
  output logic signed [15:0] col_x_o,
  output logic signed [15:0] col_y_o,
  output logic signed [15:0] col_z_o,
  output logic signed [31:0] translation_o,
  output logic               last_o
);
  import fcp_pkg::*;

  localparam int PW    = POS_BITS + 16;
  localparam int AW    = POS_BITS + 18;
  localparam int XW    = AW + 18;
  localparam int NUM_W = ANGLE_BITS + 17;
  localparam int M_W   = ANGLE_BITS + 6;
  localparam int RS    = M_W + 6;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MOVE  = 4'd1;
  localparam logic [3:0] ST_DIV   = 4'd2;
  localparam logic [3:0] ST_DAPP  = 4'd3;
  localparam logic [3:0] ST_CLOAD = 4'd4;
  localparam logic [3:0] ST_CORD  = 4'd5;
  localparam logic [3:0] ST_CFIN  = 4'd6;
  localparam logic [3:0] ST_DIRS  = 4'd7;
  localparam logic [3:0] ST_TRANS = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  localparam logic signed [AW-1:0] HALF14 = AW'(8192);
  localparam logic signed [AW-1:0] HALF6  = AW'(32);
  localparam logic signed [AW-1:0] Q_ONE  = AW'(16384);
  localparam logic signed [AW-1:0] Q_MONE = -Q_ONE;
  localparam logic signed [AW-1:0] PMAX   = AW'({1'b0, {(POS_BITS-1){1'b1}}});
  localparam logic signed [AW-1:0] PMIN   = -PMAX - AW'(1);
  localparam logic signed [XW-1:0] TMAX   = XW'(32'h7FFFFFFF);
  localparam logic signed [XW-1:0] TMIN   = -TMAX - XW'(1);
  localparam logic signed [CW-1:0] QTURN  = 34'sd1073741824;
  localparam logic signed [CW-1:0] HTURN  = 34'sd2147483648;
  localparam logic signed [CW-1:0] R16    = 34'sd32768;
  localparam logic signed [CW-1:0] C_ONE  = 34'sd16384;
  localparam logic signed [CW-1:0] C_MONE = -34'sd16384;
  localparam logic signed [NUM_W-1:0] TURN_BIAS = NUM_W'(46080);
  // ceil(2^RS / 45): exact floor(n / 45) for any n below 2^M_W
  localparam logic [M_W:0]   RECIP45  = (M_W+1)'(((64'd1 << RS) + 64'd44) / 64'd45);
  localparam logic [M_W-1:0] CEIL_ADJ = M_W'(44);

  logic [3:0]  state_q, state_d;
  logic [4:0]  step_q, step_d;
  logic [1:0]  row_q, row_d;
  logic        cs_q, cs_d;
  logic        init_q, init_d;
  logic signed [POS_BITS-1:0] pos_q [3];
  logic signed [POS_BITS-1:0] pos_d [3];
  logic [ANGLE_BITS-1:0] yaw_q, yaw_d, pitch_q, pitch_d;

  logic [2:0]         cmd_q, cmd_d;
  logic signed [15:0] amt_q, amt_d;
  logic signed [15:0] dir_q [9];
  logic signed [15:0] dir_d [9];
  logic signed [15:0] cp_q, cp_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic        flip_q, flip_d;
  logic signed [AW-1:0] acc_q, acc_d;
  logic [M_W-1:0] dq_q, dq_d;
  logic        neg_q, neg_d;
  logic [1:0]  row_o_d;
  logic signed [15:0] colx_d, coly_d, colz_d;
  logic signed [31:0] trans_d;
  logic        valid_d, last_d;

  // shared multiply-accumulate
  logic signed [15:0]       ma;
  logic signed [POS_BITS-1:0] mb;
  logic                     mneg, mclr;
  logic signed [PW-1:0]     prod;
  logic signed [AW-1:0]     acc_sum, rnd14, delta6, pos_sum;
  logic signed [15:0]       q14;
  logic signed [XW-1:0]     t_w;
  logic signed [31:0]       t_sat;
  logic signed [POS_BITS-1:0] pos_sel, pos_sat;

  // CORDIC
  logic [ANGLE_BITS-1:0] ph;
  logic [31:0]           ph32;
  logic signed [CW-1:0]  z0, dx, dy, at, xr, yr, xc, yc;
  logic signed [15:0]    c16, s16;

  // turn quotient
  logic signed [NUM_W-1:0] num;
  logic signed [M_W-1:0]   m_val;
  logic [2*M_W:0]          qprod;
  logic [M_W-1:0]          qf;

  assign prod    = PW'(ma) * PW'(mb);
  assign acc_sum = (mclr ? '0 : acc_q) + (mneg ? -AW'(prod) : AW'(prod));
  assign rnd14   = (acc_sum + HALF14) >>> 14;
  assign q14     = (rnd14 > Q_ONE) ? 16'sd16384 :
                   (rnd14 < Q_MONE) ? -16'sd16384 : $signed(rnd14[15:0]);
  assign delta6  = (acc_sum + HALF6) >>> 6;
  assign pos_sel = pos_q[step_q[1:0]];
  assign pos_sum = AW'(pos_sel) + delta6;
  assign pos_sat = (pos_sum > PMAX) ? PMAX[POS_BITS-1:0] :
                   (pos_sum < PMIN) ? PMIN[POS_BITS-1:0] : pos_sum[POS_BITS-1:0];
  assign t_w     = XW'(rnd14);
  assign t_sat   = (t_w > TMAX) ? 32'sh7FFFFFFF :
                   (t_w < TMIN) ? 32'sh80000000 : $signed(t_w[31:0]);

  assign ph   = cs_q ? pitch_q : yaw_q;
  assign ph32 = {ph, {(32-ANGLE_BITS){1'b0}}};
  assign z0   = CW'($signed(ph32));
  assign dx   = cy_q >>> step_q;
  assign dy   = cx_q >>> step_q;
  assign at   = $signed({2'b00, atan_turn(step_q)});
  assign xr   = (cx_q + R16) >>> 16;
  assign yr   = (cy_q + R16) >>> 16;
  assign xc   = (xr > C_ONE) ? C_ONE : (xr < C_MONE) ? C_MONE : xr;
  assign yc   = (yr > C_ONE) ? C_ONE : (yr < C_MONE) ? C_MONE : yr;
  assign c16  = flip_q ? -xc[15:0] : xc[15:0];
  assign s16  = flip_q ? -yc[15:0] : yc[15:0];

  // floor(num / 92160) = floor(floor(num / 2048) / 45)
  assign num   = (NUM_W'(amount_i) <<< ANGLE_BITS) + TURN_BIAS;
  assign m_val = M_W'(num >>> 11);
  assign qprod = (2*M_W+1)'(dq_q) * (2*M_W+1)'(RECIP45);
  assign qf    = neg_q ? M_W'(-dq_q) : dq_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    row_d   = row_q;
    cs_d    = cs_q;
    init_d  = init_q;
    pos_d   = pos_q;
    yaw_d   = yaw_q;
    pitch_d = pitch_q;
    cmd_d   = cmd_q;
    amt_d   = amt_q;
    dir_d   = dir_q;
    cp_d    = cp_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cz_d    = cz_q;
    flip_d  = flip_q;
    acc_d   = acc_q;
    dq_d    = dq_q;
    neg_d   = neg_q;
    row_o_d = row_o;
    colx_d  = col_x_o;
    coly_d  = col_y_o;
    colz_d  = col_z_o;
    trans_d = translation_o;
    valid_d = valid_o;
    last_d  = last_o;
    ma      = '0;
    mb      = '0;
    mneg    = 1'b0;
    mclr    = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          cmd_d  = cmd_i;
          amt_d  = amount_i;
          neg_d  = m_val[M_W-1];
          // negative: floor(m / 45) = -floor((|m| + 44) / 45)
          dq_d   = m_val[M_W-1] ? M_W'(-m_val) + CEIL_ADJ : M_W'(m_val);
          step_d = '0;
          cs_d   = 1'b0;
          unique case (cmd_i) inside
            CMD_LEFT, CMD_FRONT, CMD_UP: state_d = ST_MOVE;
            CMD_YAW, CMD_PITCH:          state_d = ST_DIV;
            default:                     state_d = ST_CLOAD;
          endcase
        end
      end
      ST_MOVE: begin
        mb = POS_BITS'(amt_q);
        case (cmd_q)
          CMD_LEFT: begin
            case (step_q[1:0])
              2'd0:    ma = dir_q[3];
              2'd1:    ma = dir_q[4];
              default: ma = dir_q[5];
            endcase
          end
          CMD_FRONT: begin
            case (step_q[1:0])
              2'd0: begin
                ma   = dir_q[5];
                mneg = 1'b1;
              end
              2'd1:    ma = '0;
              default: ma = dir_q[3];
            endcase
          end
          default: begin
            case (step_q[1:0])
              2'd0:    ma = dir_q[6];
              2'd1:    ma = dir_q[7];
              default: ma = dir_q[8];
            endcase
          end
        endcase
        pos_d[step_q[1:0]] = pos_sat;
        if (step_q == 5'd2) begin
          step_d  = '0;
          state_d = ST_CLOAD;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      ST_DIV: begin
        dq_d    = M_W'(qprod[2*M_W:RS]);
        state_d = ST_DAPP;
      end
      ST_DAPP: begin
        if (cmd_q == CMD_YAW) begin
          yaw_d = yaw_q + qf[ANGLE_BITS-1:0];
        end else begin
          pitch_d = pitch_q + qf[ANGLE_BITS-1:0];
        end
        state_d = ST_CLOAD;
      end
      ST_CLOAD: begin
        cx_d   = CORDIC_K;
        cy_d   = '0;
        step_d = '0;
        if (z0 > QTURN) begin
          cz_d   = z0 - HTURN;
          flip_d = 1'b1;
        end else if (z0 < -QTURN) begin
          cz_d   = z0 + HTURN;
          flip_d = 1'b1;
        end else begin
          cz_d   = z0;
          flip_d = 1'b0;
        end
        state_d = ST_CORD;
      end
      ST_CORD: begin
        if (!cz_q[CW-1]) begin
          cx_d = cx_q - dx;
          cy_d = cy_q + dy;
          cz_d = cz_q - at;
        end else begin
          cx_d = cx_q + dx;
          cy_d = cy_q - dy;
          cz_d = cz_q + at;
        end
        if (step_q == 5'(CORDIC_STEPS-1)) begin
          state_d = ST_CFIN;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      ST_CFIN: begin
        if (!cs_q) begin
          dir_d[3] = c16;
          dir_d[5] = -s16;
          cs_d     = 1'b1;
          state_d  = ST_CLOAD;
        end else begin
          dir_d[1] = s16;
          cp_d     = c16;
          step_d   = '0;
          state_d  = ST_DIRS;
        end
      end
      ST_DIRS: begin
        // front = (cp*sy, sp, cp*cy), up = front x left
        case (step_q[2:0])
          3'd0: begin
            ma       = cp_q;
            mb       = POS_BITS'(dir_q[5]);
            mneg     = 1'b1;
            dir_d[0] = q14;
            dir_d[4] = '0;
          end
          3'd1: begin
            ma       = cp_q;
            mb       = POS_BITS'(dir_q[3]);
            dir_d[2] = q14;
          end
          3'd2: begin
            ma       = dir_q[1];
            mb       = POS_BITS'(dir_q[5]);
            dir_d[6] = q14;
          end
          3'd3: begin
            ma = dir_q[2];
            mb = POS_BITS'(dir_q[3]);
          end
          3'd4: begin
            ma       = dir_q[0];
            mb       = POS_BITS'(dir_q[5]);
            mneg     = 1'b1;
            mclr     = 1'b0;
            dir_d[7] = q14;
          end
          default: begin
            ma       = dir_q[1];
            mb       = POS_BITS'(dir_q[3]);
            mneg     = 1'b1;
            dir_d[8] = q14;
          end
        endcase
        acc_d = acc_sum;
        if (step_q == 5'd5) begin
          step_d = '0;
          row_d  = ROW_SIDE;
          if (init_q) begin
            init_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_TRANS;
          end
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      ST_TRANS: begin
        mb   = pos_sel;
        mclr = (step_q == 5'd0);
        mneg = (row_q == ROW_UP);
        case (row_q)
          ROW_SIDE: begin
            case (step_q[1:0])
              2'd0:    ma = dir_q[3];
              2'd1:    ma = dir_q[4];
              default: ma = dir_q[5];
            endcase
          end
          ROW_UP: begin
            case (step_q[1:0])
              2'd0:    ma = dir_q[6];
              2'd1:    ma = dir_q[7];
              default: ma = dir_q[8];
            endcase
          end
          default: begin
            case (step_q[1:0])
              2'd0:    ma = dir_q[0];
              2'd1:    ma = dir_q[1];
              default: ma = dir_q[2];
            endcase
          end
        endcase
        acc_d = acc_sum;
        if (step_q == 5'd2) begin
          row_o_d = row_q;
          trans_d = t_sat;
          last_d  = (row_q == ROW_BACK);
          valid_d = 1'b1;
          case (row_q)
            ROW_SIDE: begin
              colx_d = -dir_q[3];
              coly_d = -dir_q[4];
              colz_d = -dir_q[5];
            end
            ROW_UP: begin
              colx_d = dir_q[6];
              coly_d = dir_q[7];
              colz_d = dir_q[8];
            end
            default: begin
              colx_d = -dir_q[0];
              coly_d = -dir_q[1];
              colz_d = -dir_q[2];
            end
          endcase
          state_d = ST_OUT;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      ST_OUT: begin
        if (!stall_i) begin
          valid_d = 1'b0;
          step_d  = '0;
          if (row_q == ROW_BACK) begin
            state_d = ST_IDLE;
          end else begin
            row_d   = row_q + 2'd1;
            state_d = ST_TRANS;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLOAD;
      step_q   <= '0;
      row_q    <= ROW_SIDE;
      cs_q     <= 1'b0;
      init_q   <= 1'b1;
      valid_o  <= 1'b0;
      pos_q[0] <= POS_BITS'(10) <<< 16;
      pos_q[1] <= POS_BITS'(5) <<< 16;
      pos_q[2] <= POS_BITS'(35) <<< 16;
      yaw_q    <= {1'b1, {(ANGLE_BITS-1){1'b0}}};
      pitch_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      row_q   <= row_d;
      cs_q    <= cs_d;
      init_q  <= init_d;
      valid_o <= valid_d;
      pos_q   <= pos_d;
      yaw_q   <= yaw_d;
      pitch_q <= pitch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    amt_q         <= amt_d;
    dir_q         <= dir_d;
    cp_q          <= cp_d;
    cx_q          <= cx_d;
    cy_q          <= cy_d;
    cz_q          <= cz_d;
    flip_q        <= flip_d;
    acc_q         <= acc_d;
    dq_q          <= dq_d;
    neg_q         <= neg_d;
    row_o         <= row_o_d;
    col_x_o       <= colx_d;
    col_y_o       <= coly_d;
    col_z_o       <= colz_d;
    translation_o <= trans_d;
    last_o        <= last_d;
  end

  assign stall_o = (state_q != ST_IDLE);

`ifndef SYNTHESIS
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o) else $error("result shown while accepting input");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> (stall_o && !valid_o))
    else $error("not busy after accepting a command");
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && last_o) |=> (!stall_o && !valid_o))
    else $error("not idle after last row");
  a_row_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && !last_o) |=> (!valid_o && stall_o))
    else $error("row transaction not followed by row computation");
`endif

endmodule
